@@ hw/rtl/quintic_hermite_spline_eval_top_macros.svh @@
// ============================================================================
// Assertion macros for the quintic Hermite spline evaluator
// Clocked on clk, disabled while rst_n is low; empty when SYNTHESIS is set.
// ============================================================================
`ifndef QUINTIC_HERMITE_SPLINE_EVAL_TOP_MACROS_SVH
`define QUINTIC_HERMITE_SPLINE_EVAL_TOP_MACROS_SVH

`ifndef SYNTHESIS
// plain property check
`define QHS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// condition implies consequence on the next edge
`define QHS_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define QHS_ASSERT(label, prop, msg)
`define QHS_ASSERT_NEXT(label, cond, cons, msg)
`endif

`endif

@@ hw/rtl/qhs_pkg.sv @@
// ============================================================================
// qhs_pkg
// Types, widths and constants shared by the spline evaluator modules.
// ============================================================================
package qhs_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COEFF_COUNT = 6;
    localparam int STEPS       = COEFF_COUNT - 1;   // Horner steps
    localparam int BND_W       = 32;                // boundary input width
    localparam int T_W         = FRAC_BITS + 1;     // t, Q1.F
    localparam int DERIV_W     = 2;
    localparam int COEFF_W     = 40;                // doubled coefficients
    localparam int ACC_W       = 50;                // Horner accumulator
    localparam int PROD_W      = ACC_W + T_W + 1;
    localparam int OUT_W       = 48;
    localparam int FACT_W      = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;
    localparam logic AXIS_X  = 1'b0;
    localparam logic AXIS_Y  = 1'b1;

    localparam logic [DERIV_W-1:0] DERIV_POS = 2'd0;
    localparam logic [DERIV_W-1:0] DERIV_VEL = 2'd1;
    localparam logic [DERIV_W-1:0] DERIV_ACC = 2'd2;

    localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // (j+d)!/j!, row d; the last row repeats order two
    localparam logic [FACT_W-1:0] FALL_FACT [4][COEFF_COUNT] = '{
        '{5'd1, 5'd1, 5'd1,  5'd1,  5'd1, 5'd1},
        '{5'd1, 5'd2, 5'd3,  5'd4,  5'd5, 5'd0},
        '{5'd2, 5'd6, 5'd12, 5'd20, 5'd0, 5'd0},
        '{5'd2, 5'd6, 5'd12, 5'd20, 5'd0, 5'd0}
    };

    typedef logic signed [COEFF_W-1:0] coeff_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    typedef struct packed {
        logic                      opcode;
        logic                      axis;
        logic signed [BND_W-1:0]   start_pos;
        logic signed [BND_W-1:0]   end_pos;
        logic signed [BND_W-1:0]   start_vel;
        logic signed [BND_W-1:0]   end_vel;
        logic signed [BND_W-1:0]   start_acc;
        logic signed [BND_W-1:0]   end_acc;
        logic        [T_W-1:0]     t_param;
        logic        [DERIV_W-1:0] deriv_order;
    } qhs_cmd_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x_value;
        logic signed [OUT_W-1:0] y_value;
        logic                    saturated;
    } qhs_res_t;

    // queue entry: a classified item
    typedef struct packed {
        logic                          op;
        logic                          axis;
        coeff_t [COEFF_COUNT-1:0]      coeffs;
        logic   [T_W-1:0]              t;
        logic   [DERIV_W-1:0]          deriv;
    } qhs_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qhs_qstat_t;

endpackage

@@ hw/rtl/qhs_front.sv @@
// ============================================================================
// qhs_front
// Accepts command beats, derives coefficients for loads, clamps t and order.
// ============================================================================
module qhs_front
    import qhs_pkg::*;
(
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  qhs_cmd_t   cmd,
    input  qhs_qstat_t q_stat,
    output logic       push,
    output qhs_entry_t entry
);

    coeff_t p0, v0, v1, a0, a1;
    coeff_t dp, sv, da;
    coeff_t c3, c4, c5;

    assign cmd_stall = q_stat.full;
    assign push      = cmd_valid && !q_stat.full;

    always_comb
    begin
        p0 = COEFF_W'(cmd.start_pos);
        v0 = COEFF_W'(cmd.start_vel);
        v1 = COEFF_W'(cmd.end_vel);
        a0 = COEFF_W'(cmd.start_acc);
        a1 = COEFF_W'(cmd.end_acc);
        dp = COEFF_W'(cmd.end_pos) - p0;
        sv = v0 + v1;
        da = a1 - a0;

        // doubled units: c5 = 12dp - 6(v0+v1) + (a1-a0)
        c5 = (dp <<< 3) + (dp <<< 2) - (sv <<< 2) - (sv <<< 1) + da;
        // c4 = -30dp + 16v0 + 14v1 + 3a0 - 2a1
        c4 = (dp <<< 1) - (dp <<< 5) + (v0 <<< 4) + (v1 <<< 4) - (v1 <<< 1)
           + (a0 <<< 1) + a0 - (a1 <<< 1);
        // c3 = 20dp - 12v0 - 8v1 - 3a0 + a1
        c3 = (dp <<< 4) + (dp <<< 2) - (v0 <<< 3) - (v0 <<< 2) - (v1 <<< 3)
           - (a0 <<< 1) - a0 + a1;

        entry.op        = cmd.opcode;
        entry.axis      = cmd.axis;
        entry.coeffs[5] = c5;
        entry.coeffs[4] = c4;
        entry.coeffs[3] = c3;
        entry.coeffs[2] = a0;
        entry.coeffs[1] = v0 <<< 1;
        entry.coeffs[0] = p0 <<< 1;
        entry.t         = (cmd.t_param > T_ONE) ? T_ONE : cmd.t_param;
        entry.deriv     = (cmd.deriv_order > DERIV_ACC) ? DERIV_ACC : cmd.deriv_order;
    end

endmodule

@@ hw/rtl/qhs_queue.sv @@
// ============================================================================
// qhs_queue
// Small FIFO between front and back; each side stalls on its own.
// ============================================================================
module qhs_queue
    import qhs_pkg::*;
#(
    parameter int DEPTH = 4
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  qhs_entry_t wr_entry,
    input  logic       pop,
    output qhs_entry_t rd_entry,
    output qhs_qstat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qhs_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry   = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

@@ hw/rtl/qhs_back.sv @@
// ============================================================================
// qhs_back
// Coefficient store and pipelined Horner evaluation of both axes.
// ============================================================================
module qhs_back
    import qhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qhs_qstat_t q_stat,
    input  qhs_entry_t q_head,
    output logic       pop,
    output logic       res_valid,
    input  logic       res_stall,
    output qhs_res_t   res
);

    localparam int    LAST       = 2 * STEPS;
    localparam prod_t ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

    // stage 2k holds acc after k steps, stage 2k+1 holds the product
    coeff_t               coef_reg [2][COEFF_COUNT];
    acc_t                 acc_reg  [STEPS+1][2];
    prod_t                prod_reg [STEPS][2];
    acc_t                 b_reg    [LAST+1][2][COEFF_COUNT];
    logic [T_W-1:0]       t_reg    [LAST+1];
    logic [LAST:0]        vld_reg;
    logic                 res_valid_reg;
    qhs_res_t             res_reg;

    acc_t                 ext      [2][COEFF_COUNT+2];
    acc_t                 b_new    [2][COEFF_COUNT];
    prod_t                prod_next[STEPS][2];
    prod_t                rnd      [STEPS][2];
    acc_t                 acc_next [STEPS][2];
    logic signed [ACC_W:0] half_sum [2];
    logic [ACC_W-1:0]     halved   [2];
    logic [1:0]           ovf;
    logic [OUT_W-1:0]     clamped  [2];
    logic                 adv;
    logic                 head_load;
    logic                 head_eval;

    assign adv       = !(res_valid_reg && res_stall);
    assign pop       = adv && !q_stat.empty;
    assign head_load = pop && (q_head.op == OP_LOAD);
    assign head_eval = pop && (q_head.op == OP_EVAL);

    // derivative coefficients b_j = c_(j+d) * (j+d)!/j!
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            for (int j = 0; j < COEFF_COUNT + 2; j++)
            begin
                ext[a][j] = '0;
            end
            for (int j = 0; j < COEFF_COUNT; j++)
            begin
                ext[a][j] = ACC_W'(coef_reg[a][j]);
            end
            for (int j = 0; j < COEFF_COUNT; j++)
            begin
                b_new[a][j] = ext[a][j + q_head.deriv]
                            * $signed({1'b0, FALL_FACT[q_head.deriv][j]});
            end
        end
    end

    // Horner: acc = round_half_up(acc * t / 2^F) + b_j
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            for (int a = 0; a < 2; a++)
            begin
                prod_next[k][a] = PROD_W'(acc_reg[k][a])
                                * PROD_W'($signed({1'b0, t_reg[2*k]}));
                rnd[k][a]       = (prod_reg[k][a] + ROUND_HALF) >>> FRAC_BITS;
                acc_next[k][a]  = $signed(rnd[k][a][ACC_W-1:0])
                                + b_reg[2*k+1][a][STEPS-1-k];
            end
        end
    end

    // final halving (half up) and clamp to the output range
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            half_sum[a] = {acc_reg[STEPS][a][ACC_W-1], acc_reg[STEPS][a]} + 1'b1;
            halved[a]   = half_sum[a][ACC_W:1];
            ovf[a]      = !((&halved[a][ACC_W-1:OUT_W-1]) || !(|halved[a][ACC_W-1:OUT_W-1]));
            if (!ovf[a])
            begin
                clamped[a] = halved[a][OUT_W-1:0];
            end
            else if (halved[a][ACC_W-1])
            begin
                clamped[a] = {1'b1, {(OUT_W-1){1'b0}}};
            end
            else
            begin
                clamped[a] = {1'b0, {(OUT_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 2; a++)
            begin
                for (int j = 0; j < COEFF_COUNT; j++)
                begin
                    coef_reg[a][j] <= '0;
                end
            end
        end
        else if (head_load)
        begin
            for (int j = 0; j < COEFF_COUNT; j++)
            begin
                coef_reg[q_head.axis][j] <= $signed(q_head.coeffs[j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LAST-1:0], head_eval};
            res_valid_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg[0] <= q_head.t;
            for (int a = 0; a < 2; a++)
            begin
                acc_reg[0][a] <= b_new[a][COEFF_COUNT-1];
                for (int j = 0; j < COEFF_COUNT; j++)
                begin
                    b_reg[0][a][j] <= b_new[a][j];
                end
            end
            for (int k = 0; k < STEPS; k++)
            begin
                t_reg[2*k+1] <= t_reg[2*k];
                t_reg[2*k+2] <= t_reg[2*k+1];
                for (int a = 0; a < 2; a++)
                begin
                    prod_reg[k][a]  <= prod_next[k][a];
                    acc_reg[k+1][a] <= acc_next[k][a];
                    for (int j = 0; j < COEFF_COUNT; j++)
                    begin
                        b_reg[2*k+1][a][j] <= b_reg[2*k][a][j];
                        b_reg[2*k+2][a][j] <= b_reg[2*k+1][a][j];
                    end
                end
            end
            res_reg.x_value   <= $signed(clamped[0]);
            res_reg.y_value   <= $signed(clamped[1]);
            res_reg.saturated <= |ovf;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ hw/rtl/quintic_hermite_spline_eval_top.sv @@
// ============================================================================
// quintic_hermite_spline_eval_top: two-axis quintic Hermite spline evaluator
// Throughput: one beat per cycle unless stalled; 5 Horner steps (multiply + add).
// Reset: async active low; clears queue, pipeline valids, coefficients (zero).
// ============================================================================
`include "quintic_hermite_spline_eval_top_macros.svh"

// Structure
//   front : takes a command beat, turns a load into six doubled coefficients
//           (shift/add of the boundary values), clamps t to one and the
//           derivative order to two, and pushes one entry into the queue.
//   queue : QUEUE_DEPTH entries; the front stalls only when it is full.
//   back  : pops in order. A load writes that axis's coefficient registers;
//           an evaluate snapshots the derivative coefficients of both axes
//           into the pipeline, so later loads cannot disturb it.
//           Pipeline: entry stage, then five Horner steps, each a multiply
//           stage and an add stage, then the output register with the
//           final half-up halving and the 48-bit clamp.
// Timing
//   accept -> queue write -> pop into the entry stage -> 10 Horner
//   stages -> output register.
//   Load beats give no result; they occupy one pipeline slot as a bubble.
//   The whole back pipeline holds while the output register is full and
//   stalled; the front keeps accepting until the queue fills.
module quintic_hermite_spline_eval_top
    import qhs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  qhs_cmd_t cmd,
    output logic     res_valid,
    input  logic     res_stall,
    output qhs_res_t res
);

    qhs_qstat_t q_stat;
    qhs_entry_t q_wr_entry;
    qhs_entry_t q_head;
    logic       push;
    logic       pop;

    qhs_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_stat    (q_stat),
        .push      (push),
        .entry     (q_wr_entry)
    );

    qhs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (q_wr_entry),
        .pop      (pop),
        .rd_entry (q_head),
        .stat     (q_stat)
    );

    qhs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_head    (q_head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // queue bookkeeping across front and back
    `QHS_ASSERT(a_no_push_full, q_stat.full |-> !push, "push into a full queue")
    `QHS_ASSERT(a_no_pop_empty, q_stat.empty |-> !pop, "pop from an empty queue")
    // a result held under stall must freeze the back end
    `QHS_ASSERT(a_hold_no_pop, (res_valid && res_stall) |-> !pop, "pop while output blocked")
    `QHS_ASSERT_NEXT(a_held_result, res_valid && res_stall, res_valid, "held result dropped")

endmodule
